### rtl/sorted_table_find_add_remove_defines.svh
// Assertion macros for the top-level RTL file of the sorted table.
`ifndef SORTED_TABLE_FIND_ADD_REMOVE_DEFINES_SVH
`define SORTED_TABLE_FIND_ADD_REMOVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STFAR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted table check failed");

// The consequent must hold in the cycle after the antecedent.
`define STFAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted table check failed");

`endif

### rtl/stfar_pkg.sv
package stfar_pkg;

  localparam int unsigned FieldW = 32;
  localparam int unsigned PosW   = 7;

  typedef enum logic [1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    UPD_NONE      = 2'd0,
    UPD_INSERT    = 2'd1,
    UPD_OVERWRITE = 2'd2,
    UPD_REMOVE    = 2'd3
  } upd_e;

  typedef struct packed {
    logic cmp_en;
    logic sorted;
    upd_e upd;
  } cell_ctl_t;

  typedef struct packed {
    logic cond;
    logic key_eq;
  } cell_flag_t;

  typedef struct packed {
    func_e              func;
    logic [FieldW-1:0]  search_key;
    logic [FieldW-1:0]  entry_data;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [PosW-1:0]   position;
    logic [FieldW-1:0] read_value;
    logic              status;
    logic [PosW-1:0]   count_now;
  } rsp_t;

  typedef struct packed {
    logic keep_sorted;
  } cfg_t;

endpackage

### rtl/stfar_chan_if.sv
interface stfar_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/stfar_cell.sv
module stfar_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CW         = 7
) (
  input  logic                   clk_i,
  input  stfar_pkg::cell_ctl_t   ctl_i,
  input  logic [CW-1:0]          idx_i,
  input  logic [CW-1:0]          count_i,
  input  logic [CW-1:0]          pos_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [VALUE_BITS-1:0]  val_i,
  input  logic [KEY_BITS-1:0]    left_key_i,
  input  logic [VALUE_BITS-1:0]  left_val_i,
  input  logic [KEY_BITS-1:0]    right_key_i,
  input  logic [VALUE_BITS-1:0]  right_val_i,
  output logic [KEY_BITS-1:0]    key_o,
  output logic [VALUE_BITS-1:0]  val_o,
  output stfar_pkg::cell_flag_t  flag_o
);
  import stfar_pkg::*;

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  cell_flag_t            flag_q;
  cell_flag_t            flag_d;
  logic                  occupied;
  logic                  key_eq;
  logic                  val_eq;

  assign occupied = idx_i < count_i;
  assign key_eq   = key_q == key_i;
  assign val_eq   = val_q == val_i;

  always_comb begin
    flag_d.key_eq = key_eq;
    if (ctl_i.sorted) begin
      flag_d.cond = occupied && (key_q >= key_i);
    end else begin
      flag_d.cond = occupied && key_eq && val_eq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp_en) begin
      flag_q <= flag_d;
    end
    case (ctl_i.upd)
      UPD_INSERT: begin
        if (idx_i > pos_i) begin
          key_q <= left_key_i;
          val_q <= left_val_i;
        end else if (idx_i == pos_i) begin
          key_q <= key_i;
          val_q <= val_i;
        end
      end
      UPD_OVERWRITE: begin
        if (idx_i == pos_i) begin
          key_q <= key_i;
          val_q <= val_i;
        end
      end
      UPD_REMOVE: begin
        if (idx_i >= pos_i) begin
          key_q <= right_key_i;
          val_q <= right_val_i;
        end
      end
      default: begin
      end
    endcase
  end

  assign key_o  = key_q;
  assign val_o  = val_q;
  assign flag_o = flag_q;

endmodule

### rtl/sorted_table_find_add_remove.sv
// Sorted key/value table with find, add or replace, remove and clear requests.
// Requests arrive on req_i (func, search_key, entry_data) and one result per
// request leaves on rsp_o (found, position, read_value, status, count_now).
// Both are valid/ready channels; a transfer happens when valid and ready are
// both high at a rising clock edge. cfg_i writes keep_sorted at any transfer.
// Each entry lives in one cell of a row; all cells compare the request key in
// parallel and shift toward their neighbors on insert and remove.
// An item passes from transfer in to result valid through the cell compares,
// the priority search over the cell flags and the cell update, in that order.
// A request is taken only in the idle state that follows the update, so the
// block takes no new request until the last one has been through the update.
// The result sits in an output register, and the next request is taken while
// it waits. When the receiver stalls, the update step holds until the output
// register is free. Reset empties the table and sets keep_sorted to 1. No
// clearing pass is run, so requests are taken as soon as reset is released.
module sorted_table_find_add_remove #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stfar_chan_if.sink   req_i,
  stfar_chan_if.source rsp_o,
  stfar_chan_if.sink   cfg_i
);
  import stfar_pkg::*;
  `include "sorted_table_find_add_remove_defines.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_ENC  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  func_e                 func_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CW-1:0]         count_q, count_d;
  logic                  sorted_q;
  logic [CW-1:0]         pos_q, pos_d;
  logic                  hit_q, hit_d;
  logic [VALUE_BITS-1:0] rdv_q, rdv_d;
  logic                  out_valid_q;
  rsp_t                  out_q, out_d;

  cell_ctl_t             ctl;
  logic [KEY_BITS-1:0]   cell_key [DEPTH];
  logic [VALUE_BITS-1:0] cell_val [DEPTH];
  cell_flag_t            cell_flag [DEPTH];
  logic [DEPTH-1:0]      cond_vec;
  logic [DEPTH-1:0]      keq_vec;
  logic [DEPTH-1:0]      first_oh;
  logic                  upd_go;
  logic                  req_xfer;
  upd_e                  upd_kind;

  assign req_xfer    = req_i.valid && req_i.ready;
  assign req_i.ready = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;
  assign upd_go      = (state_q == S_UPD) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          state_d = S_CMP;
        end
      end
      S_CMP: state_d = S_ENC;
      S_ENC: state_d = S_UPD;
      S_UPD: begin
        if (upd_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ctl.cmp_en = state_q == S_CMP;
  assign ctl.sorted = sorted_q;
  assign ctl.upd    = upd_go ? upd_kind : UPD_NONE;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]   lk, rk;
    logic [VALUE_BITS-1:0] lv, rv;
    if (i == 0) begin : g_first
      assign lk = key_q;
      assign lv = val_q;
    end else begin : g_left
      assign lk = cell_key[i-1];
      assign lv = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = cell_key[i];
      assign rv = cell_val[i];
    end else begin : g_right
      assign rk = cell_key[i+1];
      assign rv = cell_val[i+1];
    end
    stfar_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .CW        (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .idx_i      (CW'(i)),
      .count_i    (count_q),
      .pos_i      (pos_q),
      .key_i      (key_q),
      .val_i      (val_q),
      .left_key_i (lk),
      .left_val_i (lv),
      .right_key_i(rk),
      .right_val_i(rv),
      .key_o      (cell_key[i]),
      .val_o      (cell_val[i]),
      .flag_o     (cell_flag[i])
    );
    assign cond_vec[i] = cell_flag[i].cond;
    assign keq_vec[i]  = cell_flag[i].key_eq;
  end

  assign first_oh = cond_vec & (~cond_vec + DEPTH'(1));

  always_comb begin
    logic [CW-1:0] idx;
    idx   = '0;
    rdv_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      idx   = idx | ({CW{first_oh[i]}} & CW'(i));
      rdv_d = rdv_d | ({VALUE_BITS{first_oh[i]}} & cell_val[i]);
    end
    pos_d = (|cond_vec) ? idx : count_q;
    hit_d = (|cond_vec) && (!sorted_q || (|(first_oh & keq_vec)));
  end

  always_comb begin
    upd_kind          = UPD_NONE;
    count_d           = count_q;
    out_d.found       = hit_q;
    out_d.position    = PosW'(pos_q);
    out_d.read_value  = '0;
    out_d.status      = 1'b0;
    case (func_q)
      FUNC_FIND: begin
        if (hit_q) begin
          out_d.read_value = FieldW'(rdv_q);
        end
      end
      FUNC_ADD: begin
        if (hit_q) begin
          upd_kind = UPD_OVERWRITE;
        end else if (count_q == CW'(DEPTH)) begin
          out_d.status = 1'b1;
        end else begin
          upd_kind = UPD_INSERT;
          count_d  = count_q + CW'(1);
        end
      end
      FUNC_REMOVE: begin
        if (hit_q) begin
          upd_kind = UPD_REMOVE;
          count_d  = count_q - CW'(1);
        end
      end
      FUNC_CLEAR: begin
        count_d        = '0;
        out_d.found    = 1'b0;
        out_d.position = '0;
      end
      default: begin
      end
    endcase
    out_d.count_now = PosW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sorted_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        sorted_q <= cfg_i.payload.keep_sorted;
      end
      if (upd_go) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      func_q <= req_i.payload.func;
      key_q  <= KEY_BITS'(req_i.payload.search_key);
      val_q  <= VALUE_BITS'(req_i.payload.entry_data);
    end
    if (state_q == S_ENC) begin
      pos_q <= pos_d;
      hit_q <= hit_d;
      rdv_q <= rdv_d;
    end
    if (upd_go) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  `STFAR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
  `STFAR_ASSERT_NEXT(a_count_reported, upd_go, out_q.count_now == PosW'(count_q))
  `STFAR_ASSERT_NOW(a_full_status, out_valid_q && out_q.status, count_q == CW'(DEPTH))
  `STFAR_ASSERT_NEXT(a_insert_grows, upd_go && (upd_kind == UPD_INSERT),
                     count_q == $past(count_q) + CW'(1))

endmodule

### bench/tb_sorted_table_find_add_remove.sv
`timescale 1ns / 1ps

module tb_sorted_table_find_add_remove;
  import stfar_pkg::*;

  localparam int unsigned TabDepth = 64;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic req_valid_q = 1'b0;
  req_t req_data_q = '0;
  logic rsp_ready_q = 1'b0;
  logic cfg_valid_q = 1'b0;
  cfg_t cfg_data_q = '0;

  stfar_chan_if #(.T(req_t)) req_if ();
  stfar_chan_if #(.T(rsp_t)) rsp_if ();
  stfar_chan_if #(.T(cfg_t)) cfg_if ();

  assign req_if.valid = req_valid_q;
  assign req_if.payload = req_data_q;
  assign rsp_if.ready = rsp_ready_q;
  assign cfg_if.valid = cfg_valid_q;
  assign cfg_if.payload = cfg_data_q;

  sorted_table_find_add_remove i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Model of the table contents and mode.
  logic [FieldW-1:0] key_tab [TabDepth];
  logic [FieldW-1:0] val_tab [TabDepth];
  int unsigned tab_count;
  bit table_sorted;

  req_t queued_requests [$];
  rsp_t predicted_lookups [$];
  logic [FieldW-1:0] key_pool [$];
  logic [FieldW-1:0] val_pool [$];

  int n_errors;
  int n_sent;
  int n_checked;
  int n_hits;
  int n_full;
  int n_mode_writes;

  int burst_left;
  int gap_left;
  logic [15:0] stall_pat;
  int stall_run;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic rsp_t table_apply(req_t rq);
    rsp_t res;
    int unsigned at;
    int unsigned i;
    bit hit;
    bit done;
    res = '0;
    at = 0;
    hit = 1'b0;
    done = 1'b0;
    if (rq.func == FUNC_CLEAR) begin
      tab_count = 0;
    end else begin
      at = tab_count;
      for (i = 0; i < tab_count && !done; i++) begin
        if (table_sorted) begin
          if (key_tab[i] >= rq.search_key) begin
            hit = (key_tab[i] == rq.search_key);
            at = i;
            done = 1'b1;
          end
        end else if (key_tab[i] == rq.search_key && val_tab[i] == rq.entry_data) begin
          hit = 1'b1;
          at = i;
          done = 1'b1;
        end
      end
      case (rq.func)
        FUNC_FIND: begin
          if (hit) res.read_value = val_tab[at];
        end
        FUNC_ADD: begin
          if (hit) begin
            key_tab[at] = rq.search_key;
            val_tab[at] = rq.entry_data;
          end else if (tab_count >= TabDepth) begin
            res.status = 1'b1;
            n_full++;
          end else begin
            for (i = tab_count; i > at; i--) begin
              key_tab[i] = key_tab[i-1];
              val_tab[i] = val_tab[i-1];
            end
            key_tab[at] = rq.search_key;
            val_tab[at] = rq.entry_data;
            tab_count++;
          end
        end
        FUNC_REMOVE: begin
          if (hit) begin
            for (i = at; i + 1 < tab_count; i++) begin
              key_tab[i] = key_tab[i+1];
              val_tab[i] = val_tab[i+1];
            end
            tab_count--;
          end
        end
        default: begin
        end
      endcase
    end
    if (hit) n_hits++;
    res.found = hit;
    res.position = PosW'(at);
    res.count_now = PosW'(tab_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= 40) begin
      $display("mismatch in %s at %0t ns: got 0x%0h, expected 0x%0h", what, $time, got, want);
    end
  endtask

  task automatic check_result(rsp_t got);
    rsp_t want;
    if (predicted_lookups.size() == 0) begin
      report_mismatch("result with nothing pending", got.count_now, '0);
    end else begin
      want = predicted_lookups.pop_front();
      n_checked++;
      if (got.found !== want.found) report_mismatch("found", got.found, want.found);
      if (got.position !== want.position) begin
        report_mismatch("position", got.position, want.position);
      end
      if (got.read_value !== want.read_value) begin
        report_mismatch("read_value", got.read_value, want.read_value);
      end
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.count_now !== want.count_now) begin
        report_mismatch("count_now", got.count_now, want.count_now);
      end
    end
  endtask

  // Request driver and predictor update.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      req_data_q <= '0;
      tab_count = 0;
      table_sorted = 1'b1;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (cfg_valid_q && cfg_if.ready) begin
        table_sorted = cfg_data_q.keep_sorted;
        n_mode_writes++;
      end
      if (req_valid_q && req_if.ready) begin
        predicted_lookups.push_back(table_apply(req_data_q));
        void'(queued_requests.pop_front());
        n_sent++;
      end
      if (!req_valid_q || req_if.ready) begin
        if (gap_left > 0 || queued_requests.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_valid_q <= 1'b0;
        end else begin
          req_valid_q <= 1'b1;
          req_data_q <= queued_requests[0];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Result monitor with its own stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_q <= 1'b0;
      stall_pat <= 16'hffff;
      stall_run <= 0;
    end else begin
      if (rsp_if.valid && rsp_ready_q) check_result(rsp_if.payload);
      if (stall_run == 0) begin
        stall_run <= $urandom_range(16, 160);
        if ($urandom_range(0, 3) == 0) stall_pat <= 16'hffff;
        else stall_pat <= 16'($urandom) | 16'h0101;
        rsp_ready_q <= 1'b1;
      end else begin
        stall_run <= stall_run - 1;
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
        rsp_ready_q <= stall_pat[0];
      end
    end
  end

  task automatic push_req(func_e f, logic [FieldW-1:0] k, logic [FieldW-1:0] d);
    req_t rq;
    rq.func = f;
    rq.search_key = k;
    rq.entry_data = d;
    queued_requests.push_back(rq);
  endtask

  task automatic wait_idle();
    while (queued_requests.size() != 0 || predicted_lookups.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(bit sorted_mode);
    @(posedge clk_i);
    cfg_valid_q <= 1'b1;
    cfg_data_q.keep_sorted <= sorted_mode;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_valid_q <= 1'b0;
  endtask

  // A pool_n of zero keeps the current key pool; a val_n of zero draws
  // values freely.
  task automatic gen_requests(int n, int pool_n, int pct_add, int pct_rem, int pct_clr,
                              int val_n);
    int j;
    int roll;
    func_e f;
    logic [FieldW-1:0] k;
    logic [FieldW-1:0] d;
    if (pool_n > 0) begin
      key_pool.delete();
      key_pool.push_back('0);
      key_pool.push_back('1);
      for (j = 2; j < pool_n; j++) key_pool.push_back($urandom);
    end
    if (val_n > 0) begin
      val_pool.delete();
      val_pool.push_back('0);
      for (j = 1; j < val_n; j++) val_pool.push_back($urandom);
    end
    for (j = 0; j < n; j++) begin
      roll = $urandom_range(0, 99);
      if (roll < pct_clr) f = FUNC_CLEAR;
      else if (roll < pct_clr + pct_add) f = FUNC_ADD;
      else if (roll < pct_clr + pct_add + pct_rem) f = FUNC_REMOVE;
      else f = FUNC_FIND;
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (val_n == 0 || $urandom_range(0, 6) == 0) d = $urandom;
      else d = val_pool[$urandom_range(0, val_pool.size() - 1)];
      push_req(f, k, d);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mode(1'b1);

    push_req(FUNC_FIND, 32'h0000_0005, 32'h0);
    push_req(FUNC_REMOVE, 32'h0000_0005, 32'h0);
    push_req(FUNC_ADD, 32'h0000_0000, 32'hffff_ffff);
    push_req(FUNC_ADD, 32'hffff_ffff, 32'h0000_0000);
    push_req(FUNC_ADD, 32'h8000_0000, 32'h1234_5678);
    push_req(FUNC_FIND, 32'h0000_0000, 32'h0);
    push_req(FUNC_FIND, 32'hffff_ffff, 32'h0);
    push_req(FUNC_ADD, 32'h8000_0000, 32'ha5a5_a5a5);
    push_req(FUNC_FIND, 32'h8000_0000, 32'h0);
    push_req(FUNC_FIND, 32'h7fff_ffff, 32'h0);
    push_req(FUNC_REMOVE, 32'h0000_0000, 32'h0);
    push_req(FUNC_REMOVE, 32'h0000_0012, 32'h0);
    push_req(FUNC_FIND, 32'hffff_ffff, 32'h5a5a_5a5a);
    push_req(FUNC_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    push_req(FUNC_FIND, 32'hffff_ffff, 32'h0);
    push_req(FUNC_ADD, 32'h0000_0001, 32'h0000_0001);
    wait_idle();

    gen_requests(300, 20, 35, 25, 2, 0);
    wait_idle();

    // Fill to capacity so that adds get refused.
    push_req(FUNC_CLEAR, '0, '0);
    gen_requests(200, 96, 70, 10, 0, 0);
    wait_idle();

    write_mode(1'b0);
    gen_requests(300, 12, 40, 25, 2, 4);
    push_req(FUNC_ADD, 32'hffff_fff0, 32'h0000_0003);
    push_req(FUNC_ADD, 32'h0000_0010, 32'h0000_0002);
    push_req(FUNC_ADD, 32'h8000_0000, 32'h0000_0001);
    push_req(FUNC_ADD, 32'h0000_0001, 32'h0000_0000);
    key_pool.push_back(32'hffff_fff0);
    key_pool.push_back(32'h0000_0010);
    key_pool.push_back(32'h8000_0000);
    key_pool.push_back(32'h0000_0001);
    wait_idle();

    // Sorted searches over a table left out of order.
    write_mode(1'b1);
    gen_requests(200, 0, 30, 25, 1, 0);
    wait_idle();

    write_mode(1'b0);
    gen_requests(200, 100, 70, 10, 0, 0);
    wait_idle();

    write_mode(1'b1);
    push_req(FUNC_CLEAR, '0, '0);
    gen_requests(300, 40, 40, 25, 2, 0);
    wait_idle();

    write_mode(1'b0);
    gen_requests(200, 8, 40, 30, 2, 3);
    wait_idle();

    write_mode(1'b1);
    push_req(FUNC_CLEAR, '0, '0);
    gen_requests(150, 200, 50, 15, 0, 0);
    wait_idle();
    repeat (12) @(posedge clk_i);

    $display("Covered %0d requests and %0d checked results across %0d mode writes.",
             n_sent, n_checked, n_mode_writes);
    $display("Matches seen: %0d, adds refused on a full table: %0d, mismatches: %0d.",
             n_hits, n_full, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d requests queued and %0d results outstanding.",
             queued_requests.size(), predicted_lookups.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
